// ===== src/lla_pkg.sv =====
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types, sizes and codes of the life-like automaton engine.
// ----------------------------------------------------------------------------
package lla_pkg;

  // Grid geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);
  // Step counter covers the clearing sweep and a generation sweep up to GEN_LAST
  localparam int CNT_W = $clog2(GRID_HEIGHT + 3);

  // Row memory: one grid row per word, two buffers side by side
  localparam int RAM_AW    = ROW_W + 1;
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(GRID_HEIGHT - 1);
  localparam logic [CNT_W-1:0] GEN_LAST = CNT_W'(GRID_HEIGHT + 2);

  // Rule masks
  localparam int MASK_W = 9;
  localparam logic [MASK_W-1:0] BORN_RESET    = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BORN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_value;
  } in_t;

  typedef struct packed {
    logic read_value;
    logic done_res;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic             accept;
    logic             clr_wr;
    logic             gen_rd;
    logic             gen_shift;
    logic             gen_wr;
    logic             gen_swap;
    logic             cell_rd;
    logic             cell_wr;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== src/lla_ram.sv =====
// ----------------------------------------------------------------------------
// lla_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lla_ctrl.sv =====
// ----------------------------------------------------------------------------
// lla_ctrl
// Sequencer of the engine: clearing sweep, cell access and generation sweep.
// ----------------------------------------------------------------------------
module lla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_stall,
  input  lla_pkg::status_t status,
  output lla_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CELL  = 3'd2;
  localparam logic [2:0] S_GEN   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [lla_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.cnt       = cnt_r;
    in_stall      = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == lla_pkg::CLR_LAST) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          cnt_nxt = '0;
          if (in_op == lla_pkg::OP_WRITE || in_op == lla_pkg::OP_READ) begin
            state_nxt = S_CELL;
          end else if (in_op == lla_pkg::OP_STEP) begin
            state_nxt = S_GEN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CELL: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_GEN: begin
        // read one row ahead; write once three rows are in the window
        cmd.gen_rd    = (cnt_r < lla_pkg::GEN_LAST);
        cmd.gen_shift = (cnt_r != '0);
        cmd.gen_wr    = (cnt_r >= lla_pkg::CNT_W'(3));
        cmd.gen_swap  = (cnt_r == lla_pkg::GEN_LAST);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == lla_pkg::GEN_LAST) begin
          state_nxt = S_FIN;
          cnt_nxt   = '0;
        end
      end
      S_FIN: begin
        // hold until the output register can take the result
        cmd.out_load = status.out_free;
        cmd.cell_wr  = status.out_free;
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/lla_datapath.sv =====
// ----------------------------------------------------------------------------
// lla_datapath
// Row memory, three-row window and next-row rule logic, rule masks, item and
// result registers.
// ----------------------------------------------------------------------------
module lla_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lla_pkg::cmd_t                  cmd,
  output lla_pkg::status_t               status,
  input  lla_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lla_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::MASK_W-1:0]     cfg_data
);

  localparam int W = lla_pkg::GRID_WIDTH;

  lla_pkg::in_t                item_r, item_nxt;
  lla_pkg::out_t               res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        cur_b_r, cur_b_nxt;
  logic [lla_pkg::MASK_W-1:0]  born_r, born_nxt;
  logic [lla_pkg::MASK_W-1:0]  survive_r, survive_nxt;
  logic [W-1:0]                w_prev_r, w_prev_nxt;
  logic [W-1:0]                w_cur_r, w_cur_nxt;

  logic                        wr_en, rd_en;
  logic [lla_pkg::RAM_AW-1:0]  wr_addr, rd_addr;
  logic [W-1:0]                wr_data, rd_data;
  logic [W-1:0]                next_row, mod_row;
  logic [lla_pkg::ROW_W-1:0]   gen_rd_row, gen_wr_row, item_row;
  logic [lla_pkg::COL_W-1:0]   item_col;
  logic [lla_pkg::CNT_W-1:0]   cnt_m1, cnt_m3;
  logic                        in_grid;

  lla_ram #(
    .WIDTH (W),
    .DEPTH (lla_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next row from rows y-1 (w_prev), y (w_cur) and y+1 (read data), wrapped
  for (genvar gx = 0; gx < W; gx++) begin : g_cell
    localparam int XW = (gx == 0) ? W - 1 : gx - 1;
    localparam int XE = (gx == W - 1) ? 0 : gx + 1;
    logic [3:0] ncnt;
    assign ncnt = 4'(w_prev_r[XW]) + 4'(w_prev_r[gx]) + 4'(w_prev_r[XE])
                + 4'(w_cur_r[XW])  + 4'(w_cur_r[XE])
                + 4'(rd_data[XW])  + 4'(rd_data[gx])  + 4'(rd_data[XE]);
    assign next_row[gx] = w_cur_r[gx] ? survive_r[ncnt] : born_r[ncnt];
  end

  assign in_grid  = (32'(item_r.cell_x) < 32'(lla_pkg::GRID_WIDTH))
                 && (32'(item_r.cell_y) < 32'(lla_pkg::GRID_HEIGHT));
  assign item_col = lla_pkg::COL_W'(item_r.cell_x);
  assign item_row = lla_pkg::ROW_W'(item_r.cell_y);
  assign cnt_m1   = cmd.cnt - lla_pkg::CNT_W'(1);
  assign cnt_m3   = cmd.cnt - lla_pkg::CNT_W'(3);

  // Read order of a sweep: last row, rows 0 to last, row 0 again
  always_comb begin
    if (cmd.cnt == '0) begin
      gen_rd_row = lla_pkg::ROW_W'(lla_pkg::GRID_HEIGHT - 1);
    end else if (cmd.cnt == lla_pkg::CNT_W'(lla_pkg::GRID_HEIGHT + 1)) begin
      gen_rd_row = '0;
    end else begin
      gen_rd_row = lla_pkg::ROW_W'(cnt_m1);
    end
    gen_wr_row = lla_pkg::ROW_W'(cnt_m3);
  end

  always_comb begin
    mod_row           = rd_data;
    mod_row[item_col] = item_r.cell_value;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {cur_b_r, item_row};
    wr_data = mod_row;
    priority if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = {1'b0, lla_pkg::ROW_W'(cmd.cnt)};
      wr_data = '0;
    end else if (cmd.gen_wr) begin
      wr_en   = 1'b1;
      wr_addr = {~cur_b_r, gen_wr_row};
      wr_data = next_row;
    end else if (cmd.cell_wr) begin
      wr_en   = (item_r.operation == lla_pkg::OP_WRITE) && in_grid;
    end else begin
      wr_en   = 1'b0;
    end
  end

  assign rd_en   = cmd.gen_rd | cmd.cell_rd;
  assign rd_addr = cmd.gen_rd ? {cur_b_r, gen_rd_row} : {cur_b_r, item_row};

  always_comb begin
    item_nxt      = cmd.accept ? in_data : item_r;
    w_prev_nxt    = cmd.gen_shift ? w_cur_r : w_prev_r;
    w_cur_nxt     = cmd.gen_shift ? rd_data : w_cur_r;
    cur_b_nxt     = cmd.gen_swap ? ~cur_b_r : cur_b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt      = 1'b1;
      res_nxt.read_value = (item_r.operation == lla_pkg::OP_READ) && in_grid
                         && rd_data[item_col];
      res_nxt.done_res   = (item_r.operation == lla_pkg::OP_WRITE)
                        || (item_r.operation == lla_pkg::OP_READ)
                        || (item_r.operation == lla_pkg::OP_STEP);
    end
    born_nxt    = born_r;
    survive_nxt = survive_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        lla_pkg::CFG_BORN:    born_nxt    = cfg_data;
        lla_pkg::CFG_SURVIVE: survive_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_b_r     <= 1'b0;
      born_r      <= lla_pkg::BORN_RESET;
      survive_r   <= lla_pkg::SURVIVE_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_b_r     <= cur_b_nxt;
      born_r      <= born_nxt;
      survive_r   <= survive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    w_prev_r <= w_prev_nxt;
    w_cur_r  <= w_cur_nxt;
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = res_r;

endmodule

// ===== src/life_like_automaton_engine.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_engine
// Toroidal life-like automaton with per-cell write/read and whole-grid steps.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   lla_pkg::in_t
//   out_      output     out_valid/out_stall lla_pkg::out_t
//   cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (rule masks)
//
// Write and read items pass a cell access state; unused codes skip it.
// A generation sweeps one grid row per cycle through the single row memory
// (one read and one write port).
// After reset the current grid is cleared, with in_stall held high.
// One item is in work at a time; a finished result waits in the output
// register, and a new item is taken while it waits.
// ----------------------------------------------------------------------------
module life_like_automaton_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lla_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lla_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lla_pkg::MASK_W-1:0]     cfg_data
);

  lla_pkg::cmd_t    cmd;
  lla_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lla_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the life-like automaton engine against a cycle-free grid model.
// Cell writes, reads, generation steps and unused codes are sent in bursts
// under random output stalls. Every result is compared with the model's
// prediction, and the rule masks are changed between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
  import lla_pkg::*;

  localparam logic [1:0]           OP_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [MASK_W-1:0]    MASK_NONE   = 9'h000;
  localparam logic [MASK_W-1:0]    MASK_ALL    = 9'h1FF;
  localparam logic [MASK_W-1:0]    BORN_B36    = 9'h048;
  localparam int                   CYCLE_LIMIT = 200000;
  localparam int                   SETTLE      = 80;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0]    cfg_data  = '0;

  // Grid model, indexed [row][column]
  bit                life_grid [GRID_HEIGHT][GRID_WIDTH];
  logic [MASK_W-1:0] born_rule    = BORN_RESET;
  logic [MASK_W-1:0] survive_rule = SURVIVE_RESET;
  out_t              cell_results [$];
  out_t              want_result;

  int cycle_count;
  int mismatches;
  int items_sent;
  int steps_sent;
  int results_seen;
  int rule_writes;
  int burst_left;
  int stall_left;
  int free_left;

  life_like_automaton_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               cell_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: short stall runs separated by free stretches, some of them long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      stall_left = $urandom_range(0, 6);
      free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (cell_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: read_value=%0b done_res=%0b",
                   out_data.read_value, out_data.done_res);
      end else begin
        want_result = cell_results.pop_front();
        if (out_data.read_value !== want_result.read_value ||
            out_data.done_res !== want_result.done_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected read_value=%0b done_res=%0b, got %0b %0b",
                     results_seen, want_result.read_value, want_result.done_res,
                     out_data.read_value, out_data.done_res);
        end
      end
    end
  end

  function automatic void evolve_grid();
    bit next_grid [GRID_HEIGHT][GRID_WIDTH];
    int xe, xw, yn, ys, n;
    logic [MASK_W-1:0] rule;
    for (int y = 0; y < GRID_HEIGHT; y++) begin
      for (int x = 0; x < GRID_WIDTH; x++) begin
        xe = (x + 1) % GRID_WIDTH;
        xw = (x + GRID_WIDTH - 1) % GRID_WIDTH;
        yn = (y + 1) % GRID_HEIGHT;
        ys = (y + GRID_HEIGHT - 1) % GRID_HEIGHT;
        n  = life_grid[yn][x] + life_grid[yn][xe] + life_grid[y][xe] + life_grid[ys][xe] +
             life_grid[ys][x] + life_grid[ys][xw] + life_grid[y][xw] + life_grid[yn][xw];
        rule = life_grid[y][x] ? survive_rule : born_rule;
        next_grid[y][x] = rule[n];
      end
    end
    life_grid = next_grid;
  endfunction

  function automatic out_t predict_cell_op(in_t item);
    out_t r;
    r = '0;
    case (item.operation)
      OP_WRITE: begin
        life_grid[item.cell_y][item.cell_x] = item.cell_value;
        r.done_res = 1'b1;
      end
      OP_READ: begin
        r.read_value = life_grid[item.cell_y][item.cell_x];
        r.done_res   = 1'b1;
      end
      OP_STEP: begin
        evolve_grid();
        r.done_res = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item; valid stays high while the current burst lasts
  task automatic send_cell_op(input logic [1:0] op, input logic [5:0] x, input logic [5:0] y,
                              input logic v);
    in_t item;
    item.operation  = op;
    item.cell_x     = x;
    item.cell_y     = y;
    item.cell_value = v;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cell_results.push_back(predict_cell_op(item));
    items_sent++;
    if (op == OP_STEP) steps_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Hold the sender and wait until every pending result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (cell_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rule(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_BORN) born_rule = val;
    else if (idx == CFG_SURVIVE) survive_rule = val;
    rule_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_cell_access();
    send_cell_op(OP_WRITE, 6'd0, 6'd0, 1'b1);
    send_cell_op(OP_WRITE, 6'd63, 6'd63, 1'b1);
    send_cell_op(OP_WRITE, 6'd0, 6'd63, 1'b1);
    send_cell_op(OP_WRITE, 6'd63, 6'd0, 1'b1);
    send_cell_op(OP_READ, 6'd63, 6'd63, 1'b0);
    send_cell_op(OP_READ, 6'd0, 6'd0, 1'b1);
    send_cell_op(OP_READ, 6'd63, 6'd0, 1'b0);
    send_cell_op(OP_READ, 6'd0, 6'd63, 1'b0);
    send_cell_op(OP_READ, 6'd20, 6'd30, 1'b0);
    send_cell_op(OP_UNUSED, 6'd63, 6'd63, 1'b1);
    send_cell_op(OP_UNUSED, 6'd0, 6'd0, 1'b0);
  endtask

  // The four corners form a block across both wraps; add a blinker mid-grid
  task automatic test_default_rule();
    send_cell_op(OP_WRITE, 6'd10, 6'd10, 1'b1);
    send_cell_op(OP_WRITE, 6'd11, 6'd10, 1'b1);
    send_cell_op(OP_WRITE, 6'd12, 6'd10, 1'b1);
    send_cell_op(OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_op(OP_READ, 6'd11, 6'd9, 1'b0);
    send_cell_op(OP_READ, 6'd11, 6'd11, 1'b0);
    send_cell_op(OP_READ, 6'd10, 6'd10, 1'b0);
    send_cell_op(OP_READ, 6'd63, 6'd63, 1'b0);
  endtask

  task automatic test_rule_extremes();
    drain_results();
    write_rule(CFG_BORN, MASK_ALL);
    write_rule(CFG_SURVIVE, MASK_NONE);
    write_rule(CFG_SPARE_A, MASK_NONE);
    write_rule(CFG_SPARE_B, MASK_ALL);
    send_cell_op(OP_STEP, 6'd5, 6'd5, 1'b1);
    send_cell_op(OP_READ, 6'd40, 6'd40, 1'b0);
    send_cell_op(OP_READ, 6'd0, 6'd0, 1'b0);
    drain_results();
    write_rule(CFG_BORN, MASK_NONE);
    write_rule(CFG_SURVIVE, MASK_ALL);
    send_cell_op(OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_op(OP_READ, 6'd0, 6'd0, 1'b0);
    drain_results();
    write_rule(CFG_SURVIVE, MASK_NONE);
    send_cell_op(OP_STEP, 6'd0, 6'd0, 1'b0);
    send_cell_op(OP_READ, 6'd33, 6'd17, 1'b0);
  endtask

  // Phases of seeded patterns near a random origin, so that steps see live
  // neighborhoods, including ones that wrap around the grid edges
  task automatic test_random_traffic();
    logic [5:0] ox, oy, cx, cy;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_rule(CFG_BORN, BORN_RESET);
          write_rule(CFG_SURVIVE, SURVIVE_RESET);
        end
        2: begin
          write_rule(CFG_BORN, BORN_B36);
          write_rule(CFG_SURVIVE, SURVIVE_RESET);
          write_rule(CFG_SPARE_B, 9'($urandom));
        end
        default: begin
          write_rule(CFG_BORN, 9'($urandom) & ~9'h001);
          write_rule(CFG_SURVIVE, 9'($urandom));
        end
      endcase
      ox = 6'($urandom);
      oy = 6'($urandom);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          cx = 6'(ox + $urandom_range(0, 7));
          cy = 6'(oy + $urandom_range(0, 7));
        end else begin
          cx = 6'($urandom);
          cy = 6'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
          send_cell_op(OP_WRITE, cx, cy, $urandom_range(0, 9) < 7);
        else if (pick < 78)
          send_cell_op(OP_READ, cx, cy, 1'($urandom));
        else if (pick < 90)
          send_cell_op(OP_STEP, cx, cy, 1'($urandom));
        else
          send_cell_op(OP_UNUSED, cx, cy, 1'($urandom));
      end
    end
  endtask

  initial begin
    burst_left = $urandom_range(1, 8);
    free_left  = 4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_cell_access();
    test_default_rule();
    test_rule_extremes();
    test_random_traffic();
    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d items (%0d generation steps), %0d results checked",
             items_sent, steps_sent, results_seen);
    $display("%0d rule register writes, %0d mismatches", rule_writes, mismatches);
    if (mismatches == 0 && cell_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
